// ===== src/stpp_pkg.sv =====
// shared widths and constants of the spectral top-k peak picker
package stpp_pkg;

    localparam int POWER_W      = 32;
    localparam int BIN_STEP_W   = 24;
    localparam int PEAK_BIN_W   = 11;
    localparam int FREQ_W       = 34;

    localparam int DEF_TOP_COUNT       = 5;
    localparam int DEF_CANDIDATE_LIMIT = 128;
    localparam int DEF_FFT_POINTS      = 2048;

    localparam logic [BIN_STEP_W-1:0] BIN_STEP_RESET = BIN_STEP_W'(2688);
    localparam logic [FREQ_W-1:0]     FREQ_MAX       = {FREQ_W{1'b1}};

endpackage

// ===== src/spectral_top_peak_picker.sv =====
// top level of the streaming spectral top-k peak picker
//
// usage
// - s_ channel: one power spectrum bin per word, s_last_bin on the final bin
//   of a frame; a bin is a candidate when strictly above both neighbors,
//   first and last bins excluded, only the first CANDIDATE_LIMIT candidates
// - m_ channel: after the final bin, TOP_COUNT ranked words (rank 0 is the
//   strongest), empty ranks read zero with m_valid_res low, m_last on the
//   final rank
// - bin_step_we / bin_step_wdata: frequency per bin (Q8 Hz), write while idle
// throughput: one bin per cycle while s_ready is high; the candidate insert
//   is a parallel compare of all kept entries, done in the accept cycle
// the final bin loads the result bank, which then feeds the output register
//   with the first result; then one result per cycle while m_ready is high
// the finished list is copied to a result bank, so the next frame streams in
//   while results drain; only a final bin arriving while the bank still
//   drains is held off (s_ready low), until the bank has handed its last rank
//   to the output word
// a stalled receiver holds the output word and the bank waits; the input
//   side keeps going until the bank itself is needed again
// reset (aresetn, synchronous, active low) clears the frame state, the bank
//   and the output valid; bin_step returns to 2688
module spectral_top_peak_picker #(
    parameter int TOP_COUNT       = stpp_pkg::DEF_TOP_COUNT,
    parameter int CANDIDATE_LIMIT = stpp_pkg::DEF_CANDIDATE_LIMIT,
    parameter int FFT_POINTS      = stpp_pkg::DEF_FFT_POINTS,
    localparam int RANK_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config
    input  logic                            bin_step_we,
    input  logic [stpp_pkg::BIN_STEP_W-1:0] bin_step_wdata,
    // spectrum in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [stpp_pkg::POWER_W-1:0]    s_power,
    input  logic                            s_last_bin,
    // ranked peaks out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [RANK_W-1:0]               m_rank,
    output logic [stpp_pkg::PEAK_BIN_W-1:0] m_peak_bin,
    output logic [stpp_pkg::FREQ_W-1:0]     m_frequency,
    output logic [stpp_pkg::POWER_W-1:0]    m_amplitude,
    output logic                            m_valid_res,
    output logic                            m_last
);
    import stpp_pkg::*;

    // bins 0 .. FFT_POINTS/2 take part, the rest only count as frame end
    localparam int BINS   = FFT_POINTS / 2 + 1;
    localparam int BIN_W  = $clog2(BINS + 1);
    localparam int CC_W   = $clog2(CANDIDATE_LIMIT + 1);
    localparam int FILL_W = $clog2(TOP_COUNT + 1);
    localparam int PROD_W = BIN_W + BIN_STEP_W;
    localparam int EXT_W  = (PROD_W > FREQ_W) ? PROD_W : FREQ_W;

    logic [BIN_STEP_W-1:0] bin_step_reg;

    // frame state
    logic [POWER_W-1:0] prev_reg;
    logic [POWER_W-1:0] prev2_reg;
    logic [BIN_W-1:0]   bin_cnt_reg;
    logic [CC_W-1:0]    cand_cnt_reg;
    logic [BIN_W-1:0]   top_bin_reg [TOP_COUNT];
    logic [POWER_W-1:0] top_pow_reg [TOP_COUNT];
    logic [FILL_W-1:0]  filled_reg;

    // result bank, drained one rank per cycle while the output word is free
    logic [BIN_W-1:0]   bank_bin_reg [TOP_COUNT];
    logic [POWER_W-1:0] bank_pow_reg [TOP_COUNT];
    logic [FILL_W-1:0]  bank_filled_reg;
    logic               bank_busy_reg;
    logic [RANK_W-1:0]  emit_idx_reg;

    // output word
    logic                  m_valid_reg;
    logic [RANK_W-1:0]     m_rank_reg;
    logic [PEAK_BIN_W-1:0] m_peak_bin_reg;
    logic [FREQ_W-1:0]     m_frequency_reg;
    logic [POWER_W-1:0]    m_amplitude_reg;
    logic                  m_valid_res_reg;
    logic                  m_last_reg;

    logic               in_fire;
    logic               in_range;
    logic               is_cand;
    logic [BIN_W-1:0]   cand_bin;
    logic [FILL_W-1:0]  filled_next;
    logic [BIN_W-1:0]   top_bin_next [TOP_COUNT];
    logic [POWER_W-1:0] top_pow_next [TOP_COUNT];

    logic               out_free;
    logic               emit_valid;
    logic [BIN_W-1:0]   emit_bin;
    logic [EXT_W-1:0]   emit_prod;
    logic [FREQ_W-1:0]  emit_freq;

    // only a frame end needs the bank
    assign s_ready = !(bank_busy_reg && s_last_bin);
    assign in_fire = s_valid && s_ready;

    // peak test on the middle bin of the three-bin window
    assign in_range = bin_cnt_reg < BIN_W'(BINS);
    assign is_cand  = in_range && (bin_cnt_reg >= BIN_W'(2))
                   && (cand_cnt_reg < CC_W'(CANDIDATE_LIMIT))
                   && (prev_reg > prev2_reg) && (prev_reg > s_power);
    assign cand_bin = bin_cnt_reg - BIN_W'(1);

    stpp_insert #(
        .TOP_COUNT (TOP_COUNT),
        .BIN_W     (BIN_W),
        .FILL_W    (FILL_W)
    ) u_insert (
        .do_insert (is_cand),
        .filled_i  (filled_reg),
        .bins_i    (top_bin_reg),
        .pows_i    (top_pow_reg),
        .cand_bin  (cand_bin),
        .cand_pow  (prev_reg),
        .filled_o  (filled_next),
        .bins_o    (top_bin_next),
        .pows_o    (top_pow_next)
    );

    // result fields for the rank being sent; frequency saturates
    assign out_free   = !m_valid_reg || m_ready;
    assign emit_valid = FILL_W'(emit_idx_reg) < bank_filled_reg;
    assign emit_bin   = emit_valid ? bank_bin_reg[emit_idx_reg] : '0;
    assign emit_prod  = EXT_W'(emit_bin) * EXT_W'(bin_step_reg);
    assign emit_freq  = (emit_prod > EXT_W'(FREQ_MAX)) ? FREQ_MAX : emit_prod[FREQ_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_step_reg <= BIN_STEP_RESET;
        end else if (bin_step_we) begin
            bin_step_reg <= bin_step_wdata;
        end
    end

    // frame state and bank load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg        <= '0;
            prev2_reg       <= '0;
            bin_cnt_reg     <= '0;
            cand_cnt_reg    <= '0;
            filled_reg      <= '0;
            bank_filled_reg <= '0;
            bank_busy_reg   <= 1'b0;
            emit_idx_reg    <= '0;
            for (int i = 0; i < TOP_COUNT; i++) begin
                top_bin_reg[i]  <= '0;
                top_pow_reg[i]  <= '0;
                bank_bin_reg[i] <= '0;
                bank_pow_reg[i] <= '0;
            end
        end else begin
            // drain side
            if (out_free && bank_busy_reg) begin
                if (emit_idx_reg == RANK_W'(TOP_COUNT - 1)) begin
                    bank_busy_reg <= 1'b0;
                end else begin
                    emit_idx_reg <= emit_idx_reg + RANK_W'(1);
                end
            end
            // fill side, the bank is free whenever a final bin is taken
            if (in_fire) begin
                if (s_last_bin) begin
                    bank_bin_reg    <= top_bin_next;
                    bank_pow_reg    <= top_pow_next;
                    bank_filled_reg <= filled_next;
                    bank_busy_reg   <= 1'b1;
                    emit_idx_reg    <= '0;
                    prev_reg        <= '0;
                    prev2_reg       <= '0;
                    bin_cnt_reg     <= '0;
                    cand_cnt_reg    <= '0;
                    filled_reg      <= '0;
                    for (int i = 0; i < TOP_COUNT; i++) begin
                        top_bin_reg[i] <= '0;
                        top_pow_reg[i] <= '0;
                    end
                end else if (in_range) begin
                    prev2_reg   <= prev_reg;
                    prev_reg    <= s_power;
                    bin_cnt_reg <= bin_cnt_reg + BIN_W'(1);
                    if (is_cand) begin
                        cand_cnt_reg <= cand_cnt_reg + CC_W'(1);
                        filled_reg   <= filled_next;
                        top_bin_reg  <= top_bin_next;
                        top_pow_reg  <= top_pow_next;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= bank_busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && bank_busy_reg) begin
            m_rank_reg      <= emit_idx_reg;
            m_peak_bin_reg  <= PEAK_BIN_W'(emit_bin);
            m_frequency_reg <= emit_freq;
            m_amplitude_reg <= emit_valid ? bank_pow_reg[emit_idx_reg] : '0;
            m_valid_res_reg <= emit_valid;
            m_last_reg      <= emit_idx_reg == RANK_W'(TOP_COUNT - 1);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rank      = m_rank_reg;
    assign m_peak_bin  = m_peak_bin_reg;
    assign m_frequency = m_frequency_reg;
    assign m_amplitude = m_amplitude_reg;
    assign m_valid_res = m_valid_res_reg;
    assign m_last      = m_last_reg;

    // input is only held off for a frame end while the bank drains
    a_ready_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s_last_bin)
        else $error("input stalled on a non-final bin");

    // the ranks of one frame leave back to back
    a_ranks_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside the ranks of a frame");

    // only empty ranks follow an empty rank
    a_empty_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_valid_res && !m_last |=> !m_valid_res)
        else $error("real candidate after an empty rank");

    // an empty rank carries zero fields
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_amplitude == '0 && m_frequency == '0)
        else $error("empty rank with nonzero fields");

    // frame state is clear after a frame end
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_last_bin |=> bin_cnt_reg == '0 && filled_reg == '0 && bank_busy_reg)
        else $error("frame state not cleared after final bin");

endmodule

// ===== src/stpp_insert.sv =====
// sorted insert of one candidate into the descending top list
module stpp_insert #(
    parameter int TOP_COUNT = stpp_pkg::DEF_TOP_COUNT,
    parameter int BIN_W     = 11,
    parameter int FILL_W    = 3
) (
    input  logic                         do_insert,
    input  logic [FILL_W-1:0]            filled_i,
    input  logic [BIN_W-1:0]             bins_i [TOP_COUNT],
    input  logic [stpp_pkg::POWER_W-1:0] pows_i [TOP_COUNT],
    input  logic [BIN_W-1:0]             cand_bin,
    input  logic [stpp_pkg::POWER_W-1:0] cand_pow,
    output logic [FILL_W-1:0]            filled_o,
    output logic [BIN_W-1:0]             bins_o [TOP_COUNT],
    output logic [stpp_pkg::POWER_W-1:0] pows_o [TOP_COUNT]
);
    import stpp_pkg::*;

    // ge is a prefix mask since the list stays sorted
    logic [TOP_COUNT-1:0] ge;

    always_comb begin
        for (int i = 0; i < TOP_COUNT; i++) begin
            ge[i] = (FILL_W'(i) < filled_i) && (pows_i[i] >= cand_pow);
        end
    end

    for (genvar i = 0; i < TOP_COUNT; i++) begin : g_slot
        if (i == 0) begin : g_head
            always_comb begin
                if (!do_insert || ge[0]) begin
                    bins_o[0] = bins_i[0];
                    pows_o[0] = pows_i[0];
                end else begin
                    bins_o[0] = cand_bin;
                    pows_o[0] = cand_pow;
                end
            end
        end else begin : g_tail
            always_comb begin
                if (!do_insert || ge[i]) begin
                    bins_o[i] = bins_i[i];
                    pows_o[i] = pows_i[i];
                end else if (ge[i-1]) begin
                    bins_o[i] = cand_bin;
                    pows_o[i] = cand_pow;
                end else begin
                    bins_o[i] = bins_i[i-1];
                    pows_o[i] = pows_i[i-1];
                end
            end
        end
    end

    always_comb begin
        if (do_insert && !ge[TOP_COUNT-1] && (filled_i < FILL_W'(TOP_COUNT))) begin
            filled_o = filled_i + FILL_W'(1);
        end else begin
            filled_o = filled_i;
        end
    end

endmodule
